### rtl/llgh_pkg.sv
// Shared constants and helpers for the logistic loss gradient/Hessian unit.
`default_nettype none

package llgh_pkg;

    localparam int TABLE_DEPTH_DEF = 256;

    // |margin| limit, 12.0 in Q5.10
    localparam int MARGIN_LIMIT = 12288;
    localparam int HALF_LIMIT   = 6144;

    // sigmoid clamp values in Q0.16
    localparam logic [15:0] SIG_HIGH = 16'd65535;
    localparam logic [15:0] SIG_LOW  = 16'd1;
    localparam logic [16:0] ONE_Q16  = 17'h10000;

    localparam int LO_W   = 17;
    localparam int DIFF_W = 16;
    localparam int FRAC_W = 14;

    // ceil(2^18 / 3); exact floor(v / 3) for any 16-bit v
    localparam logic [17:0] DIV3_MUL = 18'd87382;

    function automatic logic [15:0] div3(input logic [15:0] v);
        logic [33:0] m;
        m = 34'(v) * 34'(DIV3_MUL);
        return m[33:18];
    endfunction

endpackage

`default_nettype wire

### rtl/llgh_sig_rom.sv
// Sigmoid table over [0, 12]: base value and slope to next entry, registered read.
`default_nettype none

module llgh_sig_rom
    import llgh_pkg::*;
#(
    parameter int DEPTH = TABLE_DEPTH_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_en,
    input  wire logic [$clog2(DEPTH+1)-1:0]   i_addr,
    output logic      [LO_W-1:0]              o_lo,
    output logic      [DIFF_W-1:0]            o_diff
);

    localparam int ENTRY_W = LO_W + DIFF_W;
    // exp step 12/DEPTH in Q0.32, rounded
    localparam logic [63:0] STEP = (64'd12 * (64'd1 << 32) + 64'(DEPTH / 2)) / 64'(DEPTH);

    typedef logic [ENTRY_W-1:0] t_table [0:DEPTH];

    // shift-and-subtract quotient, only used while the table is built
    function automatic logic [63:0] udiv(input logic [63:0] num, input logic [63:0] dvs);
        logic [63:0] q;
        logic [64:0] rem;
        q   = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, dvs}) begin
                rem  = rem - {1'b0, dvs};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic t_table build_table();
        logic [63:0] term;
        logic [63:0] r;
        logic [63:0] e;
        logic [63:0] den;
        logic [LO_W-1:0] tk [0:DEPTH];
        logic [LO_W-1:0] hi;
        t_table tb;
        r    = 64'd1 << 32;
        term = 64'd1 << 32;
        e    = 64'd1 << 32;
        // exp(-12/DEPTH) by truncated Taylor series
        for (int n = 1; n <= 24; n++) begin
            term = udiv((term * STEP) >> 32, 64'(n));
            if ((n % 2) == 1) begin
                r = r - term;
            end else begin
                r = r + term;
            end
        end
        for (int k = 0; k <= DEPTH; k++) begin
            if (k > 0) begin
                e = (e * r + (64'd1 << 31)) >> 32;
            end
            den   = (64'd1 << 32) + e;
            tk[k] = LO_W'(udiv((64'd1 << 48) + (den >> 1), den));
        end
        for (int k = 0; k <= DEPTH; k++) begin
            hi = (k < DEPTH) ? tk[k+1] : tk[k];
            if (hi < tk[k]) begin
                hi = tk[k];
            end
            tb[k] = {tk[k], DIFF_W'(hi - tk[k])};
        end
        return tb;
    endfunction

    localparam t_table TABLE = build_table();

    logic [ENTRY_W-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= TABLE[i_addr];
        end
    end

    assign o_lo   = r_q[ENTRY_W-1:DIFF_W];
    assign o_diff = r_q[DIFF_W-1:0];

endmodule

`default_nettype wire

### rtl/logistic_loss_grad_hess_unit.sv
// Top: streaming logistic loss gradient and Hessian, one row per unstalled cycle.
//
// Input channel (i_in_valid / o_in_ready) carries a Q5.10 margin, a 0/1 label and
// an end-of-batch flag. Output channel (o_out_valid / i_out_ready) returns
// gradient = sigmoid - label (signed Q0.16), hessian = s*(1-s) (Q0.16) and the
// end flag, one result per row, in order.
// Sigmoid: clamped outside +-12.0, otherwise a table over [0, 12] with linear
// interpolation, mirrored for negative margins.
// An accepted transaction passes through the stage registers in order, and its
// result is offered from the stage 8 output register.
// Throughput: one transaction per cycle while i_out_ready is high, set by an
// eight-stage pipeline whose stages each hold at most one multiplier.
// Each stage has its own valid bit and advances when the next stage is empty or
// moving, so a stalled receiver holds results in place while upstream bubbles
// close up; o_in_ready drops only when every stage is full.
// Reset (synchronous, active low) clears all valid bits; the table is a constant
// and needs no start-up pass.
`default_nettype none

module logistic_loss_grad_hess_unit
    import llgh_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic signed [15:0] i_margin,
    input  wire logic               i_label,
    input  wire logic               i_is_last,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic signed [16:0]      o_gradient,
    output logic        [14:0]      o_hessian,
    output logic                    o_batch_end
);

    localparam int NUM_ST = 8;
    localparam int IDX_W  = $clog2(TABLE_DEPTH + 1);
    localparam int P_W    = 17 + $clog2(TABLE_DEPTH + 1);

    logic [NUM_ST:1] r_v;
    logic [NUM_ST:1] n_v;
    logic [NUM_ST:1] en;

    // stall chain: a stage moves when it is empty or its successor moves
    always_comb begin
        en[NUM_ST] = !r_v[NUM_ST] || i_out_ready;
        for (int k = NUM_ST - 1; k >= 1; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
        n_v[1] = en[1] ? i_in_valid : r_v[1];
        for (int k = 2; k <= NUM_ST; k++) begin
            n_v[k] = en[k] ? r_v[k-1] : r_v[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= n_v;
        end
    end

    assign o_in_ready = en[1];

    // stage 1: magnitude, clamp test, scale by table depth
    logic [16:0]    n_abs;
    logic [P_W-1:0] r1_p;
    logic           r1_neg, r1_big, r1_label, r1_last;

    assign n_abs = i_margin[15] ? (17'h10000 - {1'b0, i_margin}) : {1'b0, i_margin};

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r1_p     <= P_W'(n_abs) * P_W'(TABLE_DEPTH);
            r1_neg   <= i_margin[15];
            r1_big   <= n_abs > 17'(MARGIN_LIMIT);
            r1_label <= i_label;
            r1_last  <= i_is_last;
        end
    end

    // stage 2: table index = p / 12288 = (p >> 12) / 3
    logic [15:0]      n_i;
    logic [IDX_W-1:0] r2_idx;
    logic [15:0]      r2_i;
    logic [P_W-1:0]   r2_p;
    logic             r2_neg, r2_big, r2_label, r2_last;

    assign n_i = div3(16'(r1_p >> 12));

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r2_idx   <= (n_i > 16'(TABLE_DEPTH)) ? IDX_W'(TABLE_DEPTH) : IDX_W'(n_i);
            r2_i     <= n_i;
            r2_p     <= r1_p;
            r2_neg   <= r1_neg;
            r2_big   <= r1_big;
            r2_label <= r1_label;
            r2_last  <= r1_last;
        end
    end

    // stage 3: table read and interpolation fraction
    logic [LO_W-1:0]   rom_lo;
    logic [DIFF_W-1:0] rom_diff;
    logic [P_W-1:0]    n_f_full;
    logic [FRAC_W-1:0] r3_f;
    logic              r3_neg, r3_big, r3_label, r3_last;

    llgh_sig_rom #(
        .DEPTH (TABLE_DEPTH)
    ) u_rom (
        .i_clk  (i_clk),
        .i_en   (en[3]),
        .i_addr (r2_idx),
        .o_lo   (rom_lo),
        .o_diff (rom_diff)
    );

    assign n_f_full = r2_p - (P_W'(r2_i) * P_W'(MARGIN_LIMIT));

    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r3_f     <= n_f_full[FRAC_W-1:0];
            r3_neg   <= r2_neg;
            r3_big   <= r2_big;
            r3_label <= r2_label;
            r3_last  <= r2_last;
        end
    end

    // stage 4: slope times fraction, plus half for rounding
    logic [29:0]     r4_prod;
    logic [LO_W-1:0] r4_lo;
    logic            r4_neg, r4_big, r4_label, r4_last;

    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            r4_prod  <= 30'(rom_diff) * 30'(r3_f) + 30'(HALF_LIMIT);
            r4_lo    <= rom_lo;
            r4_neg   <= r3_neg;
            r4_big   <= r3_big;
            r4_label <= r3_label;
            r4_last  <= r3_last;
        end
    end

    // stage 5: divide by 12288 and add the base value
    logic [LO_W-1:0] r5_mag;
    logic            r5_neg, r5_big, r5_label, r5_last;

    always_ff @(posedge i_clk) begin
        if (en[5]) begin
            r5_mag   <= r4_lo + LO_W'(div3(16'(r4_prod >> 12)));
            r5_neg   <= r4_neg;
            r5_big   <= r4_big;
            r5_label <= r4_label;
            r5_last  <= r4_last;
        end
    end

    // stage 6: mirror, clamp and saturate
    logic [16:0] n_sgn;
    logic [15:0] n_s;
    logic [15:0] r6_s;
    logic        r6_label, r6_last;

    always_comb begin
        n_sgn = r5_neg ? (ONE_Q16 - r5_mag) : r5_mag;
        if (r5_big) begin
            n_s = r5_neg ? SIG_LOW : SIG_HIGH;
        end else if (n_sgn > 17'(SIG_HIGH)) begin
            n_s = SIG_HIGH;
        end else if (n_sgn < 17'(SIG_LOW)) begin
            n_s = SIG_LOW;
        end else begin
            n_s = n_sgn[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[6]) begin
            r6_s     <= n_s;
            r6_label <= r5_label;
            r6_last  <= r5_last;
        end
    end

    // stage 7: gradient and raw Hessian product
    logic [30:0] r7_h;
    logic [16:0] r7_grad;
    logic        r7_last;

    always_ff @(posedge i_clk) begin
        if (en[7]) begin
            r7_h    <= 31'(34'(r6_s) * 34'(ONE_Q16 - {1'b0, r6_s}));
            r7_grad <= {1'b0, r6_s} - {r6_label, 16'b0};
            r7_last <= r6_last;
        end
    end

    // stage 8: output register, Hessian rounded to Q0.16
    logic [30:0] n_h_rnd;
    logic [14:0] r8_hess;
    logic [16:0] r8_grad;
    logic        r8_last;

    assign n_h_rnd = r7_h + 31'd32768;

    always_ff @(posedge i_clk) begin
        if (en[8]) begin
            r8_hess <= n_h_rnd[30:16];
            r8_grad <= r7_grad;
            r8_last <= r7_last;
        end
    end

    assign o_out_valid = r_v[NUM_ST];
    assign o_gradient  = $signed(r8_grad);
    assign o_hessian   = r8_hess;
    assign o_batch_end = r8_last;

endmodule

`default_nettype wire
